@@ rtl/cle_pkg.sv @@
// Package for the cursor list engine: sizes, operation and status codes, pool command.
package cle_pkg;
  localparam int Capacity  = 64;
  localparam int SlotW     = $clog2(Capacity);
  localparam int CountW    = $clog2(Capacity + 1);
  localparam int DataW     = 32;

  localparam logic [3:0] OP_APPEND     = 4'd0;
  localparam logic [3:0] OP_PREPEND    = 4'd1;
  localparam logic [3:0] OP_INS_BEFORE = 4'd2;
  localparam logic [3:0] OP_INS_AFTER  = 4'd3;
  localparam logic [3:0] OP_DEL_FRONT  = 4'd4;
  localparam logic [3:0] OP_DEL_BACK   = 4'd5;
  localparam logic [3:0] OP_DEL_CURSOR = 4'd6;
  localparam logic [3:0] OP_MV_FRONT   = 4'd7;
  localparam logic [3:0] OP_MV_BACK    = 4'd8;
  localparam logic [3:0] OP_MV_PREV    = 4'd9;
  localparam logic [3:0] OP_MV_NEXT    = 4'd10;
  localparam logic [3:0] OP_SET        = 4'd11;
  localparam logic [3:0] OP_READ       = 4'd12;
  localparam logic [3:0] OP_CLEAR      = 4'd13;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_NOCUR  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // memory command from sequencer to pool
  typedef struct packed {
    logic             nxt_we;
    logic [SlotW-1:0] nxt_addr;
    logic [SlotW-1:0] nxt_data;
    logic             prv_we;
    logic [SlotW-1:0] prv_addr;
    logic [SlotW-1:0] prv_data;
    logic             val_we;
    logic [SlotW-1:0] val_addr;
    logic [DataW-1:0] val_data;
    logic [SlotW-1:0] rd_addr;
  } pool_cmd_t;
endpackage

@@ rtl/cursor_list_engine_core.sv @@
// Top level of the cursor list engine: sequencer, pointer registers and result register.
//
// Input stream in_*: one item names an operation (tuser) and a value (tdata).
// Output stream out_*: one result per item with status, length, cursor index
// and the front, back and cursor values, packed in tdata as listed at the port.
// The node pool is three memories with one registered read port each; the
// sequencer runs every item as a series of read and link-write steps over them.
// Moves, reads and set pass from S_RD1 straight to the value refresh; appends,
// prepends and inserts at an end add S_RD2, deletes add S_LINK, inserts in the
// middle add S_RD2 and S_LINK, and cursor deletes in the middle add S_LINK and
// S_FDONE (link reads, link writes, then the value refresh reads). The walk to
// refresh front, back and cursor values needs one read of the value memory each
// over its single read port, issued in S_FH, S_FT and S_FC. Clear rewrites the
// free chain one slot a cycle. After reset the same rebuild pass runs before
// in_tready rises, and that pass produces no result. The block holds one item at
// a time; in_tready returns the cycle after the result has been taken, so a
// stalled receiver holds the whole block and the result stays stable on out_tdata.
module cursor_list_engine_core import cle_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // value[31:0]
  input  logic [3:0]   in_tuser,   // operation[3:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata   // status[1:0], list_length[8:2], cursor_position[15:9],
                                   // front_value[47:16], back_value[79:48],
                                   // cursor_value[111:80]
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;  // read data of first address valid
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_LINK  = 4'd4;
  localparam logic [3:0] S_FH    = 4'd5;  // read head value
  localparam logic [3:0] S_FT    = 4'd6;
  localparam logic [3:0] S_FC    = 4'd7;
  localparam logic [3:0] S_FDONE = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [SlotW-1:0]  clr_r, clr_nxt;
  logic [3:0]        op_r, op_nxt;
  logic [DataW-1:0]  val_r, val_nxt;
  logic [SlotW-1:0]  head_r, head_nxt, tail_r, tail_nxt, cur_r, cur_nxt, free_r, free_nxt;
  logic              cdef_r, cdef_nxt;
  logic [SlotW-1:0]  ccnt_r, ccnt_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [SlotW-1:0]  nb_r, nb_nxt;     // neighbor link read in S_RD1
  logic [SlotW-1:0]  nb2_r, nb2_nxt;
  logic [DataW-1:0]  fv_r, fv_nxt, bv_r, bv_nxt, cv_r, cv_nxt;
  logic              ov_r, ov_nxt;
  pool_cmd_t         cmd;
  logic [SlotW-1:0]  rd_next, rd_prev;
  logic [DataW-1:0]  rd_value;
  logic              empty, full;

  cle_pool u_pool (.clk(clk), .cmd(cmd), .rd_next(rd_next), .rd_prev(rd_prev),
                   .rd_value(rd_value));

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CountW'(Capacity));
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata = {cv_r, bv_r, fv_r,
                      (cdef_r ? {1'b0, ccnt_r} : 7'h7f), 7'(cnt_r), st_r};

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r; op_nxt = op_r; val_nxt = val_r;
    head_nxt = head_r; tail_nxt = tail_r; cur_nxt = cur_r; free_nxt = free_r;
    cdef_nxt = cdef_r; ccnt_nxt = ccnt_r; cnt_nxt = cnt_r; st_nxt = st_r;
    nb_nxt = nb_r; nb2_nxt = nb2_r; fv_nxt = fv_r; bv_nxt = bv_r; cv_nxt = cv_r;
    ov_nxt = ov_r;
    cmd = '0;
    cmd.rd_addr = cur_r;
    case (state_r)
      S_CLR: begin
        cmd.nxt_we = 1'b1;
        cmd.nxt_addr = clr_r;
        cmd.nxt_data = (clr_r == SlotW'(Capacity - 1)) ? '0 : clr_r + 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SlotW'(Capacity - 1)) begin
          free_nxt = '0; head_nxt = '0; tail_nxt = '0; cnt_nxt = '0;
          cdef_nxt = 1'b0; ccnt_nxt = '0; cur_nxt = '0;
          // the power-up rebuild returns to idle without a result
          state_nxt = (op_r == OP_CLEAR) ? S_FH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_tuser; val_nxt = in_tdata; st_nxt = ST_OK;
          state_nxt = S_RD1;
          cmd.rd_addr = cur_r;
          case (in_tuser)
            OP_APPEND, OP_PREPEND: begin
              if (full) st_nxt = ST_FULL;
              cmd.rd_addr = free_r;
            end
            OP_INS_BEFORE, OP_INS_AFTER, OP_DEL_CURSOR, OP_SET: begin
              if (empty) st_nxt = ST_EMPTY;
              else if (!cdef_r) st_nxt = ST_NOCUR;
              else if (full && in_tuser != OP_DEL_CURSOR && in_tuser != OP_SET)
                st_nxt = ST_FULL;
            end
            OP_DEL_FRONT: begin
              if (empty) st_nxt = ST_EMPTY;
              cmd.rd_addr = head_r;
            end
            OP_DEL_BACK: begin
              if (empty) st_nxt = ST_EMPTY;
              cmd.rd_addr = tail_r;
            end
            OP_MV_FRONT, OP_MV_BACK: if (empty) st_nxt = ST_EMPTY;
            default: ;
          endcase
          if (in_tuser == OP_CLEAR) begin
            clr_nxt = '0;
            state_nxt = S_CLR;
          end
        end
      end
      S_RD1: begin
        // read data of first address is now valid
        nb_nxt = rd_next; nb2_nxt = rd_prev;
        state_nxt = S_FH;
        if (st_r == ST_OK) begin
          case (op_r)
            OP_APPEND, OP_PREPEND, OP_INS_BEFORE, OP_INS_AFTER: begin
              cmd.rd_addr = free_r;
              state_nxt = S_RD2;
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_CURSOR: state_nxt = S_LINK;
            OP_MV_FRONT: begin
              cur_nxt = head_r; ccnt_nxt = '0; cdef_nxt = 1'b1;
            end
            OP_MV_BACK: begin
              cur_nxt = tail_r; ccnt_nxt = SlotW'(cnt_r - 1'b1); cdef_nxt = 1'b1;
            end
            OP_MV_PREV: if (cdef_r) begin
              if (cur_r == head_r) begin
                cdef_nxt = 1'b0; ccnt_nxt = '0; cur_nxt = '0;
              end else begin
                cur_nxt = rd_prev; ccnt_nxt = ccnt_r - 1'b1;
              end
            end
            OP_MV_NEXT: if (cdef_r) begin
              if (cur_r == tail_r) begin
                cdef_nxt = 1'b0; ccnt_nxt = '0; cur_nxt = '0;
              end else begin
                cur_nxt = rd_next; ccnt_nxt = ccnt_r + 1'b1;
              end
            end
            OP_SET: begin
              cmd.val_we = 1'b1; cmd.val_addr = cur_r; cmd.val_data = val_r;
            end
            default: ;
          endcase
        end
      end
      S_RD2: begin
        // rd_next is the free slot's next link; nb_r/nb2_r hold cursor links
        // (or free slot links for append/prepend, unused)
        state_nxt = S_FH;
        free_nxt = rd_next;
        cmd.val_we = 1'b1; cmd.val_addr = free_r; cmd.val_data = val_r;
        cnt_nxt = cnt_r + 1'b1;
        if (op_r == OP_APPEND || (op_r == OP_INS_AFTER && cur_r == tail_r)) begin
          if (!empty) begin
            cmd.nxt_we = 1'b1; cmd.nxt_addr = tail_r; cmd.nxt_data = free_r;
            cmd.prv_we = 1'b1; cmd.prv_addr = free_r; cmd.prv_data = tail_r;
          end else head_nxt = free_r;
          tail_nxt = free_r;
        end else if (op_r == OP_PREPEND || (op_r == OP_INS_BEFORE && cur_r == head_r)) begin
          if (!empty) begin
            cmd.nxt_we = 1'b1; cmd.nxt_addr = free_r; cmd.nxt_data = head_r;
            cmd.prv_we = 1'b1; cmd.prv_addr = head_r; cmd.prv_data = free_r;
          end else tail_nxt = free_r;
          head_nxt = free_r;
          if (cdef_r) ccnt_nxt = ccnt_r + 1'b1;
        end else if (op_r == OP_INS_BEFORE) begin
          // new between prev(c)=nb2 and c
          cmd.prv_we = 1'b1; cmd.prv_addr = free_r; cmd.prv_data = nb2_r;
          cmd.nxt_we = 1'b1; cmd.nxt_addr = free_r; cmd.nxt_data = cur_r;
          ccnt_nxt = ccnt_r + 1'b1;
          state_nxt = S_LINK;
        end else begin
          // new between c and next(c)=nb
          cmd.prv_we = 1'b1; cmd.prv_addr = nb_r; cmd.prv_data = free_r;
          cmd.nxt_we = 1'b1; cmd.nxt_addr = free_r; cmd.nxt_data = nb_r;
          state_nxt = S_LINK;
          nb2_nxt = free_r;
        end
        if (op_r == OP_INS_BEFORE && cur_r != head_r) nb_nxt = free_r;
      end
      S_LINK: begin
        state_nxt = S_FH;
        case (op_r)
          OP_INS_BEFORE: begin
            cmd.nxt_we = 1'b1; cmd.nxt_addr = nb2_r; cmd.nxt_data = nb_r;
            cmd.prv_we = 1'b1; cmd.prv_addr = cur_r; cmd.prv_data = nb_r;
          end
          OP_INS_AFTER: begin
            cmd.nxt_we = 1'b1; cmd.nxt_addr = cur_r; cmd.nxt_data = nb2_r;
            cmd.prv_we = 1'b1; cmd.prv_addr = nb2_r; cmd.prv_data = cur_r;
          end
          OP_DEL_FRONT, OP_DEL_BACK: begin
            // nb_r/nb2_r are the links of the removed end slot
            cmd.nxt_we = 1'b1;
            cmd.nxt_addr = (op_r == OP_DEL_FRONT) ? head_r : tail_r;
            cmd.nxt_data = free_r;
            free_nxt = cmd.nxt_addr;
            cnt_nxt = cnt_r - 1'b1;
            if (cdef_r && cur_r == cmd.nxt_addr) begin
              cdef_nxt = 1'b0; ccnt_nxt = '0; cur_nxt = '0;
            end else if (cdef_r && op_r == OP_DEL_FRONT && ccnt_r != '0)
              ccnt_nxt = ccnt_r - 1'b1;
            if (cnt_r == CountW'(1)) begin
              head_nxt = '0; tail_nxt = '0;
              cdef_nxt = 1'b0; ccnt_nxt = '0; cur_nxt = '0;
            end else if (op_r == OP_DEL_FRONT) head_nxt = nb_r;
            else tail_nxt = nb2_r;
          end
          default: begin
            // delete cursor
            cmd.nxt_we = 1'b1; cmd.nxt_addr = cur_r; cmd.nxt_data = free_r;
            free_nxt = cur_r;
            cnt_nxt = cnt_r - 1'b1;
            cdef_nxt = 1'b0; ccnt_nxt = '0; cur_nxt = '0;
            if (cnt_r == CountW'(1)) begin
              head_nxt = '0; tail_nxt = '0;
            end else if (ccnt_r == '0) head_nxt = nb_r;
            else if (CountW'(ccnt_r) + 1'b1 == cnt_r) tail_nxt = nb2_r;
            else begin
              state_nxt = S_RD2;
              op_nxt = OP_READ;  // second link step below
              nb_nxt = nb_r; nb2_nxt = nb2_r;
            end
          end
        endcase
        // middle delete: splice in the next cycle, in S_FDONE
        if (op_r == OP_DEL_CURSOR && state_nxt == S_RD2) state_nxt = S_FDONE;
      end
      S_FDONE: begin
        // splice prev (nb2) and next (nb) around the removed middle node
        cmd.nxt_we = 1'b1; cmd.nxt_addr = nb2_r; cmd.nxt_data = nb_r;
        cmd.prv_we = 1'b1; cmd.prv_addr = nb_r; cmd.prv_data = nb2_r;
        state_nxt = S_FH;
      end
      S_FH: begin
        cmd.rd_addr = head_r;
        state_nxt = S_FT;
      end
      S_FT: begin
        cmd.rd_addr = tail_r;
        fv_nxt = empty ? '0 : rd_value;
        state_nxt = S_FC;
      end
      S_FC: begin
        bv_nxt = empty ? '0 : rd_value;
        state_nxt = S_OUT;
        cmd.rd_addr = cur_r;
      end
      S_OUT: begin
        if (!ov_r) begin
          cv_nxt = cdef_r ? rd_value : '0;
          ov_nxt = 1'b1;
        end
        if (ov_r && out_tready) begin
          ov_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; op_r <= OP_READ;
      head_r <= '0; tail_r <= '0; cur_r <= '0; free_r <= '0;
      cdef_r <= 1'b0; ccnt_r <= '0; cnt_r <= '0; st_r <= ST_OK; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt; op_r <= op_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; cur_r <= cur_nxt; free_r <= free_nxt;
      cdef_r <= cdef_nxt; ccnt_r <= ccnt_nxt; cnt_r <= cnt_nxt; st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    val_r <= val_nxt; nb_r <= nb_nxt; nb2_r <= nb2_nxt;
    fv_r <= fv_nxt; bv_r <= bv_nxt; cv_r <= cv_nxt;
  end
endmodule

@@ rtl/cle_pool.sv @@
// Node pool: value, next and prev link memories with one registered read port each.
module cle_pool import cle_pkg::*; (
  input  logic             clk,
  input  pool_cmd_t        cmd,
  output logic [SlotW-1:0] rd_next,
  output logic [SlotW-1:0] rd_prev,
  output logic [DataW-1:0] rd_value
);
  logic [SlotW-1:0] next_mem [Capacity];
  logic [SlotW-1:0] prev_mem [Capacity];
  logic [DataW-1:0] val_mem  [Capacity];

  always_ff @(posedge clk) begin
    if (cmd.nxt_we) next_mem[cmd.nxt_addr] <= cmd.nxt_data;
    if (cmd.prv_we) prev_mem[cmd.prv_addr] <= cmd.prv_data;
    if (cmd.val_we) val_mem[cmd.val_addr] <= cmd.val_data;
    rd_next  <= next_mem[cmd.rd_addr];
    rd_prev  <= prev_mem[cmd.rd_addr];
    rd_value <= val_mem[cmd.rd_addr];
  end
endmodule

@@ tb/cursor_list_engine_core_tb.sv @@
// Testbench for the cursor list engine: directed and random list operations checked per item.
module cursor_list_engine_core_tb import cle_pkg::*; ;

  // first member sits in the highest bits, so the order mirrors out_tdata
  typedef struct packed {
    logic [31:0] cval;
    logic [31:0] back;
    logic [31:0] front;
    logic [6:0]  cpos;
    logic [6:0]  length;
    logic [1:0]  status;
  } list_view_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;
  logic [3:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;

  cursor_list_engine_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // shadow list state
  logic [31:0] sh_val [Capacity];
  logic [5:0]  sh_next [Capacity];
  logic [5:0]  sh_prev [Capacity];
  logic [5:0]  sh_head, sh_tail, sh_cur, sh_free;
  logic        sh_cdef;
  logic [5:0]  sh_ccnt;
  logic [6:0]  sh_count;

  list_view_t  view_q[$];
  int          fail_cnt;
  int          item_cnt;
  int          result_cnt;
  bit          quiet;
  int          op_seen [16];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic rebuild_chain();
    for (int i = 0; i < Capacity; i++) sh_next[i] = (i + 1 < Capacity) ? 6'(i + 1) : 6'd0;
    sh_free = 0;
  endtask

  task automatic drop_cursor();
    sh_cdef = 0; sh_ccnt = 0; sh_cur = 0;
  endtask

  function automatic logic [5:0] take_slot(logic [31:0] v);
    logic [5:0] s;
    s = sh_free;
    sh_free = sh_next[s];
    sh_val[s] = v;
    return s;
  endfunction

  task automatic give_slot(logic [5:0] s);
    sh_next[s] = sh_free;
    sh_free = s;
  endtask

  task automatic add_back(logic [31:0] v);
    logic [5:0] s;
    s = take_slot(v);
    if (sh_count == 0) sh_head = s;
    else begin
      sh_next[sh_tail] = s;
      sh_prev[s] = sh_tail;
    end
    sh_tail = s;
    sh_count++;
  endtask

  task automatic add_front(logic [31:0] v);
    logic [5:0] s;
    s = take_slot(v);
    if (sh_count == 0) sh_tail = s;
    else begin
      sh_next[s] = sh_head;
      sh_prev[sh_head] = s;
    end
    sh_head = s;
    if (sh_cdef) sh_ccnt++;
    sh_count++;
  endtask

  task automatic remove_front();
    logic [5:0] s;
    s = sh_head;
    if (sh_cdef && sh_cur == sh_head) drop_cursor();
    if (sh_count > 1) sh_head = sh_next[sh_head];
    else begin
      sh_head = 0; sh_tail = 0; drop_cursor();
    end
    if (sh_cdef && sh_ccnt > 0) sh_ccnt--;
    sh_count--;
    give_slot(s);
  endtask

  task automatic remove_back();
    logic [5:0] s;
    s = sh_tail;
    if (sh_cdef && sh_cur == sh_tail) drop_cursor();
    if (sh_count > 1) sh_tail = sh_prev[sh_tail];
    else begin
      sh_head = 0; sh_tail = 0; drop_cursor();
    end
    sh_count--;
    give_slot(s);
  endtask

  task automatic apply_op(logic [3:0] op, logic [31:0] v, output list_view_t r);
    logic [1:0] st;
    logic [5:0] c, s, nb, p, n;
    logic empty, full;
    st = ST_OK;
    c = sh_cur;
    empty = (sh_count == 0);
    full = (sh_count >= Capacity);
    case (op)
      OP_APPEND: if (full) st = ST_FULL; else add_back(v);
      OP_PREPEND: if (full) st = ST_FULL; else add_front(v);
      OP_INS_BEFORE, OP_INS_AFTER: begin
        if (empty) st = ST_EMPTY;
        else if (!sh_cdef) st = ST_NOCUR;
        else if (full) st = ST_FULL;
        else if (op == OP_INS_BEFORE && c == sh_head) add_front(v);
        else if (op == OP_INS_AFTER && c == sh_tail) add_back(v);
        else if (op == OP_INS_BEFORE) begin
          nb = sh_prev[c];
          s = take_slot(v);
          sh_prev[s] = nb; sh_next[s] = c; sh_next[nb] = s; sh_prev[c] = s;
          sh_count++; sh_ccnt++;
        end else begin
          nb = sh_next[c];
          s = take_slot(v);
          sh_prev[nb] = s; sh_next[s] = nb; sh_next[c] = s; sh_prev[s] = c;
          sh_count++;
        end
      end
      OP_DEL_FRONT: if (empty) st = ST_EMPTY; else remove_front();
      OP_DEL_BACK: if (empty) st = ST_EMPTY; else remove_back();
      OP_DEL_CURSOR: begin
        if (empty) st = ST_EMPTY;
        else if (!sh_cdef) st = ST_NOCUR;
        else if (sh_ccnt == 0) begin
          remove_front(); drop_cursor();
        end else if (7'(sh_ccnt) + 7'd1 == sh_count) begin
          remove_back(); drop_cursor();
        end else begin
          p = sh_prev[c]; n = sh_next[c];
          sh_next[p] = n; sh_prev[n] = p;
          drop_cursor(); give_slot(c); sh_count--;
        end
      end
      OP_MV_FRONT: if (empty) st = ST_EMPTY;
        else begin
          sh_cur = sh_head; sh_ccnt = 0; sh_cdef = 1;
        end
      OP_MV_BACK: if (empty) st = ST_EMPTY;
        else begin
          sh_cur = sh_tail; sh_ccnt = 6'(sh_count - 1); sh_cdef = 1;
        end
      OP_MV_PREV: if (sh_cdef) begin
          if (c == sh_head) drop_cursor();
          else begin
            sh_cur = sh_prev[c]; sh_ccnt--;
          end
        end
      OP_MV_NEXT: if (sh_cdef) begin
          if (c == sh_tail) drop_cursor();
          else begin
            sh_cur = sh_next[c]; sh_ccnt++;
          end
        end
      OP_SET: begin
        if (empty) st = ST_EMPTY;
        else if (!sh_cdef) st = ST_NOCUR;
        else sh_val[c] = v;
      end
      OP_CLEAR: begin
        rebuild_chain();
        sh_head = 0; sh_tail = 0; drop_cursor(); sh_count = 0;
      end
      default: ;
    endcase
    r.status = st;
    r.length = sh_count;
    r.cpos = sh_cdef ? {1'b0, sh_ccnt} : 7'h7f;
    r.front = sh_count != 0 ? sh_val[sh_head] : 32'd0;
    r.back = sh_count != 0 ? sh_val[sh_tail] : 32'd0;
    r.cval = sh_cdef ? sh_val[sh_cur] : 32'd0;
  endtask

  task automatic send_item(logic [3:0] op, logic [31:0] v);
    list_view_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_op(op, v, r);
    view_q.push_back(r);
    op_seen[op]++;
    item_cnt++;
    in_tvalid <= 0;
    // the block stays busy after an accept
    @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (quiet) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    list_view_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      result_cnt++;
      if (view_q.size() == 0) begin
        $error("result with nothing expected: %h", out_tdata);
        fail_cnt++;
      end else begin
        want = view_q.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); fail_cnt++;
        end
        if (got.length !== want.length) begin
          $error("list_length exp %0d got %0d", want.length, got.length); fail_cnt++;
        end
        if (got.cpos !== want.cpos) begin
          $error("cursor_position exp %h got %h", want.cpos, got.cpos); fail_cnt++;
        end
        if (got.front !== want.front) begin
          $error("front_value exp %h got %h", want.front, got.front); fail_cnt++;
        end
        if (got.back !== want.back) begin
          $error("back_value exp %h got %h", want.back, got.back); fail_cnt++;
        end
        if (got.cval !== want.cval) begin
          $error("cursor_value exp %h got %h", want.cval, got.cval); fail_cnt++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_cases();
    for (int op = 0; op < 16; op++)
      if (op != OP_APPEND && op != OP_PREPEND) send_item(4'(op), 32'hdead_beef);
  endtask

  task automatic test_basic_ops();
    send_item(OP_APPEND, 32'h7fff_ffff);
    send_item(OP_INS_AFTER, 32'h1);
    send_item(OP_PREPEND, 32'h8000_0000);
    send_item(OP_MV_FRONT, 0);
    send_item(OP_MV_PREV, 0);
    send_item(OP_MV_NEXT, 0);
    send_item(OP_SET, 32'h5555_aaaa);
    send_item(OP_MV_FRONT, 0);
    send_item(OP_MV_NEXT, 0);
    send_item(OP_INS_BEFORE, 32'haaaa_5555);
    send_item(OP_INS_AFTER, 32'h1234_5678);
    send_item(OP_DEL_CURSOR, 0);
    send_item(OP_MV_BACK, 0);
    send_item(OP_MV_NEXT, 0);
    send_item(OP_MV_NEXT, 0);
    send_item(OP_DEL_FRONT, 0);
    send_item(OP_DEL_BACK, 0);
    send_item(OP_CLEAR, 0);
  endtask

  task automatic test_pool_full();
    while (sh_count < Capacity) send_item(OP_APPEND, rand_value());
    send_item(OP_APPEND, 32'h1);
    send_item(OP_MV_BACK, 0);
    send_item(OP_INS_BEFORE, 32'h2);
    send_item(OP_DEL_CURSOR, 0);
    send_item(OP_CLEAR, 0);
  endtask

  task automatic test_random_ops(int n);
    int k;
    logic [3:0] op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      // bias inserts while short, deletes while long
      if (k < 30) op = (sh_count > 48) ? 4'($urandom_range(4, 6)) : 4'($urandom_range(0, 3));
      else if (k < 45) op = 4'($urandom_range(0, 3));
      else if (k < 60) op = 4'($urandom_range(4, 6));
      else if (k < 90) op = 4'($urandom_range(7, 11));
      else if (k < 99) op = 4'($urandom_range(12, 15));
      else op = OP_CLEAR;
      send_item(op, rand_value());
    end
  endtask

  initial begin
    int guard;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    out_tready = 0;
    quiet = 0;
    fail_cnt = 0;
    item_cnt = 0;
    result_cnt = 0;
    for (int i = 0; i < 16; i++) op_seen[i] = 0;
    for (int i = 0; i < Capacity; i++) begin
      sh_val[i] = 0; sh_prev[i] = 0;
    end
    rebuild_chain();
    sh_head = 0; sh_tail = 0; drop_cursor(); sh_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_empty_cases();
    test_basic_ops();
    test_pool_full();
    test_random_ops(900);
    test_pool_full();
    quiet = 1;
    test_random_ops(150);
    guard = 0;
    while (view_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    $display("Sent %0d items, got %0d results; clears seen %0d, sets %0d.",
             item_cnt, result_cnt, op_seen[OP_CLEAR], op_seen[OP_SET]);
    $display("Covered empty, undefined cursor, full pool and step-off cases.");
    if (fail_cnt == 0 && view_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

@@ cursor_list_engine_core.f @@
rtl/cle_pkg.sv
rtl/cle_pool.sv
rtl/cursor_list_engine_core.sv
tb/cursor_list_engine_core_tb.sv
